/* design/pd_steering_controller_macros.svh */
// Assertion macros used by the steering controller checker.
`ifndef PD_STEERING_CONTROLLER_MACROS_SVH
`define PD_STEERING_CONTROLLER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define PDSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pdsc check failed");

// Next-cycle implication, masked while reset is asserted.
`define PDSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pdsc check failed");

// Implication that is also checked through reset.
`define PDSC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("pdsc check failed");

`endif

/* design/pdsc_pkg.sv */
package pdsc_pkg;

    // Field widths
    localparam int ERR_W  = 8;
    localparam int GAIN_W = 16;
    localparam int CNT_W  = 16;
    localparam int CMD_W  = 8;
    localparam int SUM_W  = 27;
    localparam int IDX_W  = 2;

    // Register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_P_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_D_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd2;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0] P_GAIN_RST = 16'd384;
    localparam logic [GAIN_W-1:0] D_GAIN_RST = 16'd5120;
    localparam logic [CNT_W-1:0]  PERIOD_RST = 16'd10;

    // Saturation limits on the signed Q19.8 sum, and command limits
    localparam logic signed [SUM_W-1:0] SUM_HI = 27'sd32512;
    localparam logic signed [SUM_W-1:0] SUM_LO = -27'sd32768;
    localparam logic signed [CMD_W-1:0] CMD_MAX = 8'sd127;
    localparam logic signed [CMD_W-1:0] CMD_MIN = -8'sd128;

    // Input kind codes
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_CONTROL = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] p_gain;
        logic [GAIN_W-1:0] d_gain;
    } gains_t;

endpackage

/* design/pdsc_law.sv */
module pdsc_law (
    input  pdsc_pkg::gains_t                  gains,
    input  logic signed [pdsc_pkg::ERR_W-1:0] cur_err,
    input  logic signed [pdsc_pkg::ERR_W-1:0] prev_err,
    output logic signed [pdsc_pkg::CMD_W-1:0] command
);

    logic signed [24:0]                  p_term;
    logic signed [8:0]                   diff;
    logic signed [25:0]                  d_term;
    logic signed [pdsc_pkg::SUM_W-1:0]   sum;
    logic signed [pdsc_pkg::SUM_W-1:0]   biased;

    // Proportional and derivative products, gains taken as unsigned Q8.8
    assign p_term = $signed({9'd0, gains.p_gain}) * 25'(cur_err);
    assign diff   = $signed({cur_err[7], cur_err}) - $signed({prev_err[7], prev_err});
    assign d_term = $signed({10'd0, gains.d_gain}) * 26'(diff);

    assign sum = -$signed({{2{p_term[24]}}, p_term}) - $signed({d_term[25], d_term});

    // Bias negative sums so the shift truncates toward zero
    assign biased = sum[pdsc_pkg::SUM_W-1] ? (sum + 27'sd255) : sum;

    // Saturate, otherwise drop the fraction bits
    always_comb begin
        if (sum > pdsc_pkg::SUM_HI) begin
            command = pdsc_pkg::CMD_MAX;
        end else if (sum < pdsc_pkg::SUM_LO) begin
            command = pdsc_pkg::CMD_MIN;
        end else begin
            command = biased[15:8];
        end
    end

endmodule

/* design/pd_steering_controller.sv */
// PD steering controller.
// A firing control transaction's command goes through the error and command registers.
// Throughput: one input transaction per cycle unless both stages are full and m_tready
// is low; the products are computed between the error register and the command register.
// Reset: synchronous active-low aresetn restores the gains, the period, the tick
// counter and the error history, and empties both pipeline stages.
module pd_steering_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // [7:0] line_position, [8] line_present
    input  logic                            s_tuser,  // [0] kind
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // [7:0] servo_command
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdsc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [15:0]                     cfg_data
);

    logic [pdsc_pkg::GAIN_W-1:0]        p_gain_reg;
    logic [pdsc_pkg::GAIN_W-1:0]        d_gain_reg;
    logic [pdsc_pkg::CNT_W-1:0]         period_reg;
    logic [pdsc_pkg::CNT_W-1:0]         tick_reg;
    logic [pdsc_pkg::CNT_W-1:0]         tick_next;
    logic signed [pdsc_pkg::ERR_W-1:0]  cur_err_reg;
    logic signed [pdsc_pkg::ERR_W-1:0]  prev_err_reg;
    logic                               stage_valid_reg;
    logic                               out_valid_reg;
    logic signed [pdsc_pkg::CMD_W-1:0]  out_cmd_reg;
    logic signed [pdsc_pkg::CMD_W-1:0]  law_cmd;
    pdsc_pkg::gains_t                   gains;
    logic                               in_acc;
    logic                               advance;
    logic                               fire;

    assign cfg_ready = 1'b1;

    // Pipeline flow: the stage moves on when the output register is free or drains
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !stage_valid_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    // An update needs a control transaction, an elapsed period and a visible line
    assign fire = in_acc && (s_tuser == pdsc_pkg::KIND_CONTROL)
                  && (tick_reg > period_reg) && s_tdata[8];

    // Tick counter, saturating, cleared on an update
    always_comb begin
        tick_next = tick_reg;
        if (fire) begin
            tick_next = '0;
        end else if (in_acc && (s_tuser == pdsc_pkg::KIND_TICK) && (tick_reg != '1)) begin
            tick_next = tick_reg + 16'd1;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg <= pdsc_pkg::P_GAIN_RST;
            d_gain_reg <= pdsc_pkg::D_GAIN_RST;
            period_reg <= pdsc_pkg::PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pdsc_pkg::REG_P_GAIN: p_gain_reg <= cfg_data;
                pdsc_pkg::REG_D_GAIN: d_gain_reg <= cfg_data;
                pdsc_pkg::REG_PERIOD: period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Counter and error history; the stage flag marks a fresh pair to evaluate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            cur_err_reg     <= '0;
            prev_err_reg    <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            tick_reg <= tick_next;
            if (fire) begin
                prev_err_reg <= cur_err_reg;
                cur_err_reg  <= $signed(s_tdata[7:0]);
            end
            if (in_acc) begin
                stage_valid_reg <= fire;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    assign gains.p_gain = p_gain_reg;
    assign gains.d_gain = d_gain_reg;

    pdsc_law u_law (
        .gains    (gains),
        .cur_err  (cur_err_reg),
        .prev_err (prev_err_reg),
        .command  (law_cmd)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage_valid_reg) begin
            out_cmd_reg <= law_cmd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cmd_reg;

endmodule

/* design/pdsc_checker.sv */
`include "pd_steering_controller_macros.svh"

module pdsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [15:0]                     s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [7:0]                      m_tdata
);

    // A held result keeps its valid and its command
    `PDSC_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `PDSC_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // A fresh result follows an accepted control transaction with a line, through the error and command registers
    `PDSC_ASSERT_NOW(a_rose_cause, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready && (s_tuser == pdsc_pkg::KIND_CONTROL) && s_tdata[8], 2))

    // Nothing is offered in the cycle after reset
    `PDSC_ASSERT_ALWAYS(a_reset_empty, aclk, !$past(aresetn), !m_tvalid)

endmodule

bind pd_steering_controller pdsc_checker u_pdsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
